@@ sv/vfc_pkg.sv @@
package vfc_pkg;

  typedef enum logic [1:0] {
    REQ_CAM   = 2'd0,
    REQ_BOX   = 2'd1,
    REQ_BOXXZ = 2'd2,
    REQ_POINT = 2'd3
  } req_e;

  localparam logic [2:0] CFG_NEAR   = 3'd0;
  localparam logic [2:0] CFG_FAR    = 3'd1;
  localparam logic [2:0] CFG_LEFT   = 3'd2;
  localparam logic [2:0] CFG_RIGHT  = 3'd3;
  localparam logic [2:0] CFG_BOTTOM = 3'd4;
  localparam logic [2:0] CFG_TOP    = 3'd5;

  localparam logic [2:0] PLANE_LEFT   = 3'd0;
  localparam logic [2:0] PLANE_RIGHT  = 3'd1;
  localparam logic [2:0] PLANE_BOTTOM = 3'd2;
  localparam logic [2:0] PLANE_TOP    = 3'd3;
  localparam logic [2:0] PLANE_NEAR   = 3'd4;
  localparam logic [2:0] PLANE_FAR    = 3'd5;
  localparam logic [2:0] PLANE_NONE   = 3'd6;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } item_t;

  typedef struct packed {
    logic [30:0]        near_dist;
    logic [30:0]        far_dist;
    logic signed [31:0] left_edge;
    logic signed [31:0] right_edge;
    logic signed [31:0] bottom_edge;
    logic signed [31:0] top_edge;
  } cfg_t;

  function automatic logic signed [65:0] ext32(input logic signed [31:0] x);
    return {{34{x[31]}}, x};
  endfunction

  function automatic logic signed [65:0] ext64(input logic signed [63:0] x);
    return {{2{x[63]}}, x};
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
    return {x[31], x};
  endfunction

  // Clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic fits32(input logic signed [63:0] v);
    return (&v[63:31]) | ~(|v[63:31]);
  endfunction

  // Cyclic neighbors of a vector component
  function automatic logic [1:0] nx1(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic [1:0] nx2(input logic [1:0] i);
    return (i == 2'd0) ? 2'd2 : i - 2'd1;
  endfunction

  // Plane order of a point test: sides, far, then near
  function automatic logic [2:0] point_plane(input logic [2:0] idx);
    logic [2:0] r;
    case (idx)
      3'd4:    r = PLANE_FAR;
      3'd5:    r = PLANE_NEAR;
      default: r = idx;
    endcase
    return r;
  endfunction

endpackage

@@ sv/vfc_front.sv @@
module vfc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vfc_pkg::item_t      in_item_i,
  output logic                q_valid_o,
  output vfc_pkg::item_t      q_item_o,
  input  logic                q_pop_i
);

  vfc_pkg::item_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i & ~in_stall_o;
  assign pop        = q_pop_i & (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];

  // Queue requests between front and back
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ sv/vfc_back.sv @@
module vfc_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vfc_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  vfc_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           culled_o,
  output logic [2:0]     plane_hit_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_CAM, S_TVEC, S_CROSS, S_NORM, S_TEST, S_DONE
  } state_e;

  state_e             state_q;
  logic [3:0]         step_q;
  logic               ph_q;
  logic [2:0]         pl_q;
  logic [2:0]         tk_q, tp_q;
  logic [1:0]         tc_q;
  logic [2:0]         hit_q;
  vfc_pkg::item_t     it_q;
  logic signed [31:0] eye_q [3];
  logic signed [31:0] np_q  [3];
  logic signed [31:0] fp_q  [3];
  logic signed [31:0] nrm_q [6][3];
  logic signed [31:0] c2n_q [3];
  logic signed [31:0] sl_q  [3];
  logic signed [31:0] t_q   [3];
  logic signed [63:0] cr_q  [3];
  logic signed [64:0] acc_q;
  logic signed [63:0] mul_q;
  logic               res_valid_q, res_culled_q;
  logic [2:0]         res_hit_q;

  logic signed [31:0] av [3], bv [3], sv [3];
  logic signed [31:0] uv [3], wv [3], vv [3];
  logic signed [31:0] cor [3], refv [3];
  logic signed [31:0] edge_sel;
  logic signed [32:0] opa, opb;
  logic signed [65:0] prod;
  logic signed [63:0] mul_d;
  logic [1:0]         ck, ci;
  logic [2:0]         pa, lastk;
  logic               hx, hz, all_fit, corner_out;
  logic signed [64:0] sum;
  logic               res_load;

  assign av = '{it_q.ax, it_q.ay, it_q.az};
  assign bv = '{it_q.bx, it_q.by, it_q.bz};
  assign sv = '{it_q.cx, it_q.cy, it_q.cz};

  // Select side-plane operands
  always_comb begin
    case (pl_q)
      vfc_pkg::PLANE_LEFT: begin
        edge_sel = cfg_i.left_edge;   vv = sv;   uv = sl_q; wv = t_q;
      end
      vfc_pkg::PLANE_RIGHT: begin
        edge_sel = cfg_i.right_edge;  vv = sv;   uv = t_q;  wv = sl_q;
      end
      vfc_pkg::PLANE_BOTTOM: begin
        edge_sel = cfg_i.bottom_edge; vv = sl_q; uv = t_q;  wv = sv;
      end
      default: begin
        edge_sel = cfg_i.top_edge;    vv = sl_q; uv = sv;   wv = t_q;
      end
    endcase
  end

  // Form the tested corner and its reference point
  assign pa    = (it_q.req_type == vfc_pkg::REQ_POINT) ? vfc_pkg::point_plane(tp_q) : tp_q;
  assign hx    = (tk_q == 3'd1) || (tk_q == 3'd2) || (tk_q == 3'd5) || (tk_q == 3'd6);
  assign hz    = (tk_q == 3'd2) || (tk_q == 3'd3) || (tk_q == 3'd6) || (tk_q == 3'd7);
  assign lastk = (it_q.req_type == vfc_pkg::REQ_BOX)   ? 3'd7 :
                 (it_q.req_type == vfc_pkg::REQ_BOXXZ) ? 3'd3 : 3'd0;

  always_comb begin
    cor[0] = hx ? it_q.bx : it_q.ax;
    cor[2] = hz ? it_q.bz : it_q.az;
    if (it_q.req_type == vfc_pkg::REQ_BOXXZ) begin
      cor[1] = 32'sd0;
    end else begin
      cor[1] = tk_q[2] ? it_q.by : it_q.ay;
    end
    if (pa < vfc_pkg::PLANE_NEAR) begin
      refv = eye_q;
    end else if (pa == vfc_pkg::PLANE_NEAR) begin
      refv = np_q;
    end else begin
      refv = fp_q;
    end
  end

  // Drive the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    ck  = 2'd0;
    ci  = step_q[2:1];
    case (state_q)
      S_CAM: begin
        if (step_q < 4'd3) begin
          ck  = step_q[1:0];
          opa = vfc_pkg::sx33(bv[ck]);
          opb = $signed({2'b00, cfg_i.near_dist});
        end else if (step_q < 4'd6) begin
          ck  = 2'(step_q - 4'd3);
          opa = vfc_pkg::sx33(bv[ck]);
          opb = $signed({2'b00, cfg_i.far_dist});
        end else begin
          ci = 2'((step_q - 4'd6) >> 1);
          if (!step_q[0]) begin
            opa = vfc_pkg::sx33(sv[vfc_pkg::nx1(ci)]);
            opb = vfc_pkg::sx33(bv[vfc_pkg::nx2(ci)]);
          end else begin
            opa = vfc_pkg::sx33(sv[vfc_pkg::nx2(ci)]);
            opb = vfc_pkg::sx33(bv[vfc_pkg::nx1(ci)]);
          end
        end
      end
      S_TVEC: begin
        ck  = step_q[1:0];
        opa = vfc_pkg::sx33(edge_sel);
        opb = vfc_pkg::sx33(vv[ck]);
      end
      S_CROSS: begin
        if (!step_q[0]) begin
          opa = vfc_pkg::sx33(uv[vfc_pkg::nx1(ci)]);
          opb = vfc_pkg::sx33(wv[vfc_pkg::nx2(ci)]);
        end else begin
          opa = vfc_pkg::sx33(uv[vfc_pkg::nx2(ci)]);
          opb = vfc_pkg::sx33(wv[vfc_pkg::nx1(ci)]);
        end
      end
      S_TEST: begin
        ck  = (tc_q == 2'd3) ? 2'd0 : tc_q;
        opa = vfc_pkg::sx33(nrm_q[pa][ck]);
        opb = vfc_pkg::sx33(cor[ck]) - vfc_pkg::sx33(refv[ck]);
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign prod       = opa * opb;
  assign mul_d      = 64'(prod >>> FRAC_BITS);
  assign all_fit    = vfc_pkg::fits32(cr_q[0]) & vfc_pkg::fits32(cr_q[1]) &
                      vfc_pkg::fits32(cr_q[2]);
  assign sum        = acc_q + 65'(vfc_pkg::ext64(mul_q));
  assign corner_out = ~sum[64];
  assign q_pop_o    = (state_q == S_IDLE) & q_valid_i;
  assign res_load   = (state_q == S_DONE) & (~res_valid_q | ~out_stall_i);

  assign out_valid_o = res_valid_q;
  assign culled_o    = res_culled_q;
  assign plane_hit_o = res_hit_q;

  // Sequence camera rebuilds and culling tests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      ph_q         <= 1'b0;
      pl_q         <= '0;
      tk_q         <= '0;
      tp_q         <= '0;
      tc_q         <= '0;
      hit_q        <= '0;
      it_q         <= '0;
      eye_q        <= '{default: '0};
      np_q         <= '{default: '0};
      fp_q         <= '{default: '0};
      nrm_q        <= '{default: '{default: '0}};
      c2n_q        <= '{default: '0};
      sl_q         <= '{default: '0};
      t_q          <= '{default: '0};
      cr_q         <= '{default: '0};
      acc_q        <= '0;
      mul_q        <= '0;
      res_valid_q  <= 1'b0;
      res_culled_q <= 1'b0;
      res_hit_q    <= '0;
    end else begin
      mul_q <= mul_d;
      // Load a finished result or retire the one that was taken
      if (res_load) begin
        res_valid_q  <= 1'b1;
        res_culled_q <= (hit_q != vfc_pkg::PLANE_NONE);
        res_hit_q    <= hit_q;
      end else if (res_valid_q && !out_stall_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            it_q   <= q_item_i;
            step_q <= '0;
            ph_q   <= 1'b0;
            tk_q   <= '0;
            tp_q   <= '0;
            tc_q   <= '0;
            state_q <= (q_item_i.req_type == vfc_pkg::REQ_CAM) ? S_CAM : S_TEST;
          end
        end
        S_CAM: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (step_q < 4'd3) begin
              c2n_q[ck] <= vfc_pkg::sat32(vfc_pkg::ext64(mul_q));
              np_q[ck]  <= vfc_pkg::sat32(vfc_pkg::ext32(av[ck]) +
                           vfc_pkg::ext32(vfc_pkg::sat32(vfc_pkg::ext64(mul_q))));
            end else if (step_q < 4'd6) begin
              eye_q[ck] <= av[ck];
              fp_q[ck]  <= vfc_pkg::sat32(vfc_pkg::ext32(av[ck]) +
                           vfc_pkg::ext32(vfc_pkg::sat32(vfc_pkg::ext64(mul_q))));
            end else if (!step_q[0]) begin
              acc_q <= 65'(vfc_pkg::ext64(mul_q));
            end else begin
              sl_q[ci] <= vfc_pkg::sat32(vfc_pkg::ext64(acc_q[63:0]) -
                          vfc_pkg::ext64(mul_q));
            end
            if (step_q == 4'd11) begin
              state_q <= S_TVEC;
              step_q  <= '0;
              pl_q    <= vfc_pkg::PLANE_LEFT;
            end else begin
              step_q <= step_q + 4'd1;
            end
          end
        end
        S_TVEC: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            t_q[ck] <= vfc_pkg::sat32(vfc_pkg::ext32(c2n_q[ck]) +
                       vfc_pkg::ext32(vfc_pkg::sat32(vfc_pkg::ext64(mul_q))));
            if (step_q == 4'd2) begin
              state_q <= S_CROSS;
              step_q  <= '0;
            end else begin
              step_q <= step_q + 4'd1;
            end
          end
        end
        S_CROSS: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (!step_q[0]) begin
              acc_q <= 65'(vfc_pkg::ext64(mul_q));
            end else begin
              cr_q[ci] <= acc_q[63:0] - mul_q;
            end
            if (step_q == 4'd5) begin
              state_q <= S_NORM;
              step_q  <= '0;
            end else begin
              step_q <= step_q + 4'd1;
            end
          end
        end
        S_NORM: begin
          if (all_fit) begin
            for (int k = 0; k < 3; k++) begin
              nrm_q[pl_q][k] <= cr_q[k][31:0];
            end
            if (pl_q < vfc_pkg::PLANE_TOP) begin
              pl_q    <= pl_q + 3'd1;
              state_q <= S_TVEC;
              step_q  <= '0;
            end else if (pl_q == vfc_pkg::PLANE_TOP) begin
              pl_q <= vfc_pkg::PLANE_NEAR;
              for (int k = 0; k < 3; k++) begin
                cr_q[k] <= 64'sd0 - 64'(vfc_pkg::ext32(bv[k]));
              end
            end else if (pl_q == vfc_pkg::PLANE_NEAR) begin
              pl_q <= vfc_pkg::PLANE_FAR;
              for (int k = 0; k < 3; k++) begin
                cr_q[k] <= 64'(vfc_pkg::ext32(bv[k]));
              end
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            for (int k = 0; k < 3; k++) begin
              cr_q[k] <= cr_q[k] >>> 1;
            end
          end
        end
        S_TEST: begin
          if (tc_q == 2'd1) begin
            acc_q <= 65'(vfc_pkg::ext64(mul_q));
          end else if (tc_q == 2'd2) begin
            acc_q <= sum;
          end
          if (tc_q != 2'd3) begin
            tc_q <= tc_q + 2'd1;
          end else begin
            tc_q <= '0;
            if (corner_out) begin
              if (tk_q == lastk) begin
                hit_q   <= pa;
                state_q <= S_DONE;
              end else begin
                tk_q <= tk_q + 3'd1;
              end
            end else begin
              tk_q <= '0;
              if (tp_q == vfc_pkg::PLANE_FAR) begin
                hit_q   <= vfc_pkg::PLANE_NONE;
                state_q <= S_DONE;
              end else begin
                tp_q <= tp_q + 3'd1;
              end
            end
          end
        end
        S_DONE: begin
          if (res_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/view_frustum_cull.sv @@
// A point test checks the side planes, then far, then near, and stops at the
// first plane it lies outside; a box test checks the corners against each plane
// in turn. A camera update shifts each normal right until it fits in 32 bits.
// Throughput is set by the single shared 33x33 multiplier in the back end;
// a two-entry request queue lets the front keep accepting meanwhile.
// Reset (rst_ni low, asynchronous) clears the queue, state and all normals.
module view_frustum_cull #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] az_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  input  logic signed [31:0] bz_i,
  input  logic signed [31:0] cx_i,
  input  logic signed [31:0] cy_i,
  input  logic signed [31:0] cz_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               culled_o,
  output logic [2:0]         plane_hit_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  vfc_pkg::cfg_t  cfg_q;
  vfc_pkg::item_t in_item, q_item;
  logic           q_valid, q_pop;

  assign in_item = '{req_type: req_type_i, ax: ax_i, ay: ay_i, az: az_i,
                     bx: bx_i, by: by_i, bz: bz_i, cx: cx_i, cy: cy_i, cz: cz_i};

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_dist   <= 31'd65536;
      cfg_q.far_dist    <= 31'd6553600;
      cfg_q.left_edge   <= -32'sd65536;
      cfg_q.right_edge  <= 32'sd65536;
      cfg_q.bottom_edge <= -32'sd65536;
      cfg_q.top_edge    <= 32'sd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vfc_pkg::CFG_NEAR:   cfg_q.near_dist   <= cfg_data_i[30:0];
        vfc_pkg::CFG_FAR:    cfg_q.far_dist    <= cfg_data_i[30:0];
        vfc_pkg::CFG_LEFT:   cfg_q.left_edge   <= cfg_data_i;
        vfc_pkg::CFG_RIGHT:  cfg_q.right_edge  <= cfg_data_i;
        vfc_pkg::CFG_BOTTOM: cfg_q.bottom_edge <= cfg_data_i;
        vfc_pkg::CFG_TOP:    cfg_q.top_edge    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  vfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  vfc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .culled_o    (culled_o),
    .plane_hit_o (plane_hit_o)
  );

endmodule

@@ sv/vfc_check.sv @@
module vfc_check (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       culled_o,
  input logic [2:0] plane_hit_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(culled_o) && $stable(plane_hit_o))
    else $error("stalled result changed");

  // Culled flag agrees with the reported plane
  a_culled_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (culled_o == (plane_hit_o != vfc_pkg::PLANE_NONE)))
    else $error("culled flag and plane disagree");

  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (plane_hit_o != 3'd7))
    else $error("plane index out of range");

endmodule

bind view_frustum_cull vfc_check u_vfc_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .culled_o    (culled_o),
  .plane_hit_o (plane_hit_o)
);

@@ tb/sv/tb_top.sv @@
module tb_top;

  localparam int FRAC = 16;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 1000;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint ONE = 64'sd65536;

  typedef struct {
    logic       culled;
    logic [2:0] plane_hit;
  } verdict_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i = '0;
  logic signed [31:0] ax_i = '0, ay_i = '0, az_i = '0;
  logic signed [31:0] bx_i = '0, by_i = '0, bz_i = '0;
  logic signed [31:0] cx_i = '0, cy_i = '0, cz_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               culled_o;
  logic [2:0]         plane_hit_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;

  view_frustum_cull dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of registers and frustum state
  longint near_dist, far_dist;
  longint edge_reg [6];
  longint eye_pos [3], near_pt [3], far_pt [3];
  longint normal [18];

  verdict_t verdicts [$];
  int       errors = 0;
  longint   cycles = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       hold_left = 0;

  // Report one mismatch and count it
  task automatic report(input string what);
    errors++;
    if (errors <= 30) $display("mismatch @%0d: %s", cycles, what);
  endtask

  function automatic longint sat(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  // Q16.16 product with a wide intermediate, floor shift
  function automatic longint qmul(input longint a, input longint b);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = pa * pb;
    return longint'(p >>> FRAC);
  endfunction

  function automatic void cross3(input longint a [3], input longint b [3],
                                 output longint r [3]);
    r[0] = qmul(a[1], b[2]) - qmul(a[2], b[1]);
    r[1] = qmul(a[2], b[0]) - qmul(a[0], b[2]);
    r[2] = qmul(a[0], b[1]) - qmul(a[1], b[0]);
  endfunction

  function automatic bit in32(input longint v);
    return v >= QMIN && v <= QMAX;
  endfunction

  // Shift all three components by the smallest common amount that fits
  function automatic void keep_normal(input int plane, input longint n [3]);
    int s;
    s = 0;
    while (s < 63 && !(in32(n[0] >>> s) && in32(n[1] >>> s) && in32(n[2] >>> s)))
      s++;
    for (int k = 0; k < 3; k++) normal[plane*3 + k] = n[k] >>> s;
  endfunction

  function automatic void edge_offset(input longint c2n [3], input longint e,
                                      input longint v [3], output longint r [3]);
    for (int k = 0; k < 3; k++) r[k] = sat(c2n[k] + sat(qmul(e, v[k])));
  endfunction

  function automatic void reset_frustum();
    near_dist = 65536;
    far_dist = 6553600;
    edge_reg[vfc_pkg::CFG_LEFT] = -65536;
    edge_reg[vfc_pkg::CFG_RIGHT] = 65536;
    edge_reg[vfc_pkg::CFG_BOTTOM] = -65536;
    edge_reg[vfc_pkg::CFG_TOP] = 65536;
    for (int k = 0; k < 3; k++) begin
      eye_pos[k] = 0;
      near_pt[k] = 0;
      far_pt[k] = 0;
    end
    for (int k = 0; k < 18; k++) normal[k] = 0;
  endfunction

  // Rebuild planes from eye, look and strafe
  function automatic void rebuild_frustum(input longint a [3], input longint b [3],
                                          input longint s [3]);
    longint c2n [3], sl [3], t [3], n [3], neg [3];
    for (int k = 0; k < 3; k++) begin
      eye_pos[k] = a[k];
      c2n[k] = sat(qmul(b[k], near_dist));
      near_pt[k] = sat(a[k] + c2n[k]);
      far_pt[k] = sat(a[k] + sat(qmul(b[k], far_dist)));
      neg[k] = -b[k];
    end
    cross3(s, b, sl);
    for (int k = 0; k < 3; k++) sl[k] = sat(sl[k]);
    edge_offset(c2n, edge_reg[vfc_pkg::CFG_TOP], sl, t);
    cross3(s, t, n);
    keep_normal(vfc_pkg::PLANE_TOP, n);
    edge_offset(c2n, edge_reg[vfc_pkg::CFG_BOTTOM], sl, t);
    cross3(t, s, n);
    keep_normal(vfc_pkg::PLANE_BOTTOM, n);
    edge_offset(c2n, edge_reg[vfc_pkg::CFG_LEFT], s, t);
    cross3(sl, t, n);
    keep_normal(vfc_pkg::PLANE_LEFT, n);
    edge_offset(c2n, edge_reg[vfc_pkg::CFG_RIGHT], s, t);
    cross3(t, sl, n);
    keep_normal(vfc_pkg::PLANE_RIGHT, n);
    keep_normal(vfc_pkg::PLANE_FAR, b);
    keep_normal(vfc_pkg::PLANE_NEAR, neg);
  endfunction

  function automatic bit outside(input int plane, input longint px, input longint py,
                                 input longint pz);
    longint r [3];
    longint sum;
    for (int k = 0; k < 3; k++)
      r[k] = plane < 4 ? eye_pos[k] :
             (plane == vfc_pkg::PLANE_NEAR ? near_pt[k] : far_pt[k]);
    sum = qmul(normal[plane*3], px - r[0]) + qmul(normal[plane*3 + 1], py - r[1])
        + qmul(normal[plane*3 + 2], pz - r[2]);
    return sum >= 0;
  endfunction

  // Classify a box or point against the current frustum
  function automatic verdict_t classify(input vfc_pkg::req_e kind, input longint a [3],
                                        input longint b [3]);
    verdict_t v;
    int hit, cnt, p;
    bit all_out;
    longint x, y, z;
    hit = vfc_pkg::PLANE_NONE;
    if (kind == vfc_pkg::REQ_POINT) begin
      for (int i = 0; i < 6 && hit == vfc_pkg::PLANE_NONE; i++) begin
        p = (i == 4) ? vfc_pkg::PLANE_FAR : (i == 5) ? vfc_pkg::PLANE_NEAR : i;
        if (outside(p, a[0], a[1], a[2])) hit = p;
      end
    end else begin
      cnt = (kind == vfc_pkg::REQ_BOX) ? 8 : 4;
      for (p = 0; p < 6 && hit == vfc_pkg::PLANE_NONE; p++) begin
        all_out = 1'b1;
        for (int k = 0; k < cnt && all_out; k++) begin
          x = (k == 1 || k == 2 || k == 5 || k == 6) ? b[0] : a[0];
          z = (k == 2 || k == 3 || k == 6 || k == 7) ? b[2] : a[2];
          y = (kind == vfc_pkg::REQ_BOXXZ) ? 0 : (k >= 4 ? b[1] : a[1]);
          if (!outside(p, x, y, z)) all_out = 1'b0;
        end
        if (all_out) hit = p;
      end
    end
    v.culled = (hit != vfc_pkg::PLANE_NONE);
    v.plane_hit = hit[2:0];
    return v;
  endfunction

  // Drive one request and wait for it to be taken
  task automatic send(input vfc_pkg::req_e kind, input logic signed [31:0] f [9]);
    longint a [3], b [3], s [3];
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    ax_i <= f[0]; ay_i <= f[1]; az_i <= f[2];
    bx_i <= f[3]; by_i <= f[4]; bz_i <= f[5];
    cx_i <= f[6]; cy_i <= f[7]; cz_i <= f[8];
    do @(posedge clk_i); while (in_stall_o);
    for (int k = 0; k < 3; k++) begin
      a[k] = f[k];
      b[k] = f[3 + k];
      s[k] = f[6 + k];
    end
    if (kind == vfc_pkg::REQ_CAM) rebuild_frustum(a, b, s);
    else verdicts.push_back(classify(kind, a, b));
    // Now and then drop valid for a random while between requests
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == vfc_pkg::CFG_NEAR) near_dist = data[30:0];
    else if (idx == vfc_pkg::CFG_FAR) far_dist = data[30:0];
    else if (idx <= vfc_pkg::CFG_TOP) edge_reg[idx] = longint'(signed'(data));
  endtask

  // Small Q16.16 value within +-range units, full range now and then
  function automatic logic signed [31:0] rq(input int range);
    if ($urandom_range(19) == 0) return $urandom;
    return $signed($urandom_range(2 * range * 65536)) - range * 65536;
  endfunction

  task automatic send_camera();
    logic signed [31:0] f [9];
    int axis;
    axis = $urandom_range(2);
    for (int k = 0; k < 9; k++) f[k] = rq(4);
    // Mostly a unit look with a perpendicular unit strafe
    if ($urandom_range(4) != 0) begin
      for (int k = 3; k < 9; k++) f[k] = 0;
      f[3 + axis] = $urandom_range(1) ? ONE : -ONE;
      f[6 + (axis + 1) % 3] = $urandom_range(1) ? ONE : -ONE;
    end
    send(vfc_pkg::REQ_CAM, f);
  endtask

  task automatic send_query();
    logic signed [31:0] f [9];
    vfc_pkg::req_e kind;
    kind = vfc_pkg::req_e'($urandom_range(vfc_pkg::REQ_POINT, vfc_pkg::REQ_BOX));
    for (int k = 0; k < 9; k++) f[k] = rq(40);
    if (kind != vfc_pkg::REQ_POINT && $urandom_range(3) != 0)
      for (int k = 3; k < 6; k++) f[k] = f[k - 3] + rq(6);
    send(kind, f);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) send_camera();
      else send_query();
    end
  endtask

  task automatic random_config();
    write_reg(vfc_pkg::CFG_NEAR,
              $urandom_range(3) == 0 ? $urandom : $urandom_range(4 * 65536));
    write_reg(vfc_pkg::CFG_FAR,
              $urandom_range(3) == 0 ? $urandom : $urandom_range(400 * 65536));
    for (int i = vfc_pkg::CFG_LEFT; i <= vfc_pkg::CFG_TOP; i++)
      write_reg(i[2:0], $urandom_range(3) == 0 ? $urandom : rq(2));
  endtask

  // Result checker and receiver stall
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdicts.size() == 0) begin
        report("result with nothing expected");
      end else begin
        if (culled_o !== verdicts[0].culled)
          report($sformatf("culled got %b want %b", culled_o, verdicts[0].culled));
        if (plane_hit_o !== verdicts[0].plane_hit)
          report($sformatf("plane_hit got %0d want %0d", plane_hit_o,
                           verdicts[0].plane_hit));
        void'(verdicts.pop_front());
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic test_before_update();
    logic signed [31:0] f [9];
    for (int t = vfc_pkg::REQ_BOX; t <= vfc_pkg::REQ_POINT; t++) begin
      for (int k = 0; k < 9; k++) f[k] = rq(10);
      send(vfc_pkg::req_e'(t), f);
    end
  endtask

  task automatic test_directed();
    logic signed [31:0] f [9];
    logic signed [31:0] ext [4];
    ext = '{32'sh7fffffff, 32'sh80000000, 0, -1};
    // Standard camera at origin looking down -z
    f = '{0, 0, 0, 0, 0, -ONE, ONE, 0, 0};
    send(vfc_pkg::REQ_CAM, f);
    f = '{0, 0, -5 * ONE, 0, 0, 0, 0, 0, 0};
    send(vfc_pkg::REQ_POINT, f);
    f = '{0, 0, 5 * ONE, 0, 0, 0, 0, 0, 0};
    send(vfc_pkg::REQ_POINT, f);
    f = '{0, 0, -500 * ONE, 0, 0, 0, 0, 0, 0};
    send(vfc_pkg::REQ_POINT, f);
    f = '{-ONE, -ONE, -6 * ONE, ONE, ONE, -4 * ONE, 0, 0, 0};
    send(vfc_pkg::REQ_BOX, f);
    // Box with lower above upper
    f = '{ONE, ONE, -4 * ONE, -ONE, -ONE, -6 * ONE, 0, 0, 0};
    send(vfc_pkg::REQ_BOX, f);
    send(vfc_pkg::REQ_BOXXZ, f);
    f = '{50 * ONE, 0, -3 * ONE, 60 * ONE, ONE, -2 * ONE, 0, 0, 0};
    send(vfc_pkg::REQ_BOXXZ, f);
    // Field extremes
    foreach (ext[i]) begin
      for (int k = 0; k < 9; k++) f[k] = ext[(i + k) % 4];
      send(vfc_pkg::REQ_POINT, f);
      send(vfc_pkg::REQ_BOX, f);
      send(vfc_pkg::REQ_BOXXZ, f);
    end
    for (int k = 0; k < 9; k++) f[k] = ext[0];
    send(vfc_pkg::REQ_CAM, f);
    send(vfc_pkg::REQ_BOX, f);
    for (int k = 0; k < 9; k++) f[k] = ext[1];
    send(vfc_pkg::REQ_CAM, f);
    send(vfc_pkg::REQ_POINT, f);
    // Zero look collapses every normal
    f = '{ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0};
    send(vfc_pkg::REQ_CAM, f);
    send(vfc_pkg::REQ_POINT, f);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(vfc_pkg::CFG_NEAR, 32'h0);
    write_reg(vfc_pkg::CFG_FAR, 32'hffffffff);
    write_reg(vfc_pkg::CFG_LEFT, 32'h80000000);
    write_reg(vfc_pkg::CFG_RIGHT, 32'h7fffffff);
    write_reg(vfc_pkg::CFG_BOTTOM, 32'h80000000);
    write_reg(vfc_pkg::CFG_TOP, 32'h7fffffff);
    write_reg(3'd6, $urandom);
    write_reg(3'd7, $urandom);
    run_random(60);
    drain();
    write_reg(vfc_pkg::CFG_NEAR, 32'h7fffffff);
    write_reg(vfc_pkg::CFG_FAR, 32'h0);
    for (int i = vfc_pkg::CFG_LEFT; i <= vfc_pkg::CFG_TOP; i++) write_reg(i[2:0], 32'h0);
    run_random(60);
    drain();
  endtask

  task automatic test_idle_phases();
    int pct [4][2];
    pct = '{'{0, 0}, '{80, 0}, '{0, 80}, '{16, 16}};
    for (int r = 0; r < 2; r++) begin
      foreach (pct[i]) begin
        idle_pct = pct[i][0];
        stall_pct = pct[i][1];
        random_config();
        run_random(220);
        drain();
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_left = 800;
    run_random(40);
    drain();
    // Pause the sender until every result is back
    run_random(30);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
    run_random(30);
    drain();
  endtask

  initial begin
    reset_frustum();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_before_update();
    drain();
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_idle_phases();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/vfc_pkg.sv
sv/vfc_front.sv
sv/vfc_back.sv
sv/view_frustum_cull.sv
sv/vfc_check.sv
tb/sv/tb_top.sv
